// ===== rtl/core/lslf_pkg.sv =====
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared types, constants and the fit program for the least-squares line fit.
// ----------------------------------------------------------------------------
package lslf_pkg;

	localparam int SMP_W       = 16;
	localparam int CNT_W       = 13;
	localparam int MAX_SAMPLES = 4096;
	localparam int FRAC_BITS   = 16;
	localparam int SX_W        = 29;
	localparam int SXX_W       = 44;
	localparam int SXY_W       = 45;
	localparam int W           = 192;  // wide word of the fit engine
	localparam int RA          = 4;    // register file address width
	localparam int IT_W        = 8;    // iteration counter width
	localparam int PC_W        = 6;
	localparam int LD_W        = 3;
	localparam int FLD_W       = 48;
	localparam int SQ_IN_W     = 2 * FLD_W;
	localparam int MRS_W       = 16;

	typedef enum logic [2:0] {
		OP_MUL,
		OP_SUB,
		OP_SHL,
		OP_DIV,
		OP_SQRT,
		OP_DEG,
		OP_OUT,
		OP_END
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [RA-1:0] d;
		logic [RA-1:0] a;
		logic [RA-1:0] b;
		logic [7:0]    imm;
	} instr_t;

	typedef struct packed {
		logic            start;
		instr_t          instr;
		logic            ld_we;
		logic [LD_W-1:0] ld_sel;
		logic            clr_sat;
		logic            zero_fields;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic deg;
		logic sat;
	} dp_sts_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             ovf;
	} acc_sts_t;

	// status codes
	localparam logic [2:0] ST_OK  = 3'd0;
	localparam logic [2:0] ST_FEW = 3'd1;
	localparam logic [2:0] ST_DEG = 3'd2;
	localparam logic [2:0] ST_SAT = 3'd3;
	localparam logic [2:0] ST_OVF = 3'd4;

	// register file map; the first eight are loaded from the sums
	localparam logic [RA-1:0] R_N   = 4'd0;
	localparam logic [RA-1:0] R_N2  = 4'd1;
	localparam logic [RA-1:0] R_SX  = 4'd2;
	localparam logic [RA-1:0] R_SY  = 4'd3;
	localparam logic [RA-1:0] R_SXX = 4'd4;
	localparam logic [RA-1:0] R_SYY = 4'd5;
	localparam logic [RA-1:0] R_SXY = 4'd6;
	localparam logic [RA-1:0] R_MRS = 4'd7;
	localparam logic [RA-1:0] R_T0  = 4'd8;
	localparam logic [RA-1:0] R_T1  = 4'd9;
	localparam logic [RA-1:0] R_DX  = 4'd10;
	localparam logic [RA-1:0] R_DXY = 4'd11;
	localparam logic [RA-1:0] R_DY  = 4'd12;
	localparam logic [RA-1:0] R_QS  = 4'd12;  // reuses DY once Q is formed
	localparam logic [RA-1:0] R_Q   = 4'd13;
	localparam logic [RA-1:0] R_D2  = 4'd14;
	localparam logic [RA-1:0] R_NN2 = 4'd15;

	localparam logic [LD_W-1:0] LD_LAST = 3'd7;

	// output field selects
	localparam logic [7:0] F_SLOPE = 8'd0;
	localparam logic [7:0] F_ICPT  = 8'd1;
	localparam logic [7:0] F_SERR  = 8'd2;
	localparam logic [7:0] F_IERR  = 8'd3;
	localparam logic [7:0] F_RSD   = 8'd4;

	localparam logic [7:0] SH_SPREAD = 8'd16;
	localparam logic [7:0] SH_F      = 8'(FRAC_BITS);
	localparam logic [7:0] SH_2F     = 8'(2 * FRAC_BITS);

	function automatic instr_t mk(input op_t op, input logic [RA-1:0] d,
		input logic [RA-1:0] a, input logic [RA-1:0] b, input logic [7:0] imm);
		instr_t r;
		r.op  = op;
		r.d   = d;
		r.a   = a;
		r.b   = b;
		r.imm = imm;
		return r;
	endfunction

	function automatic instr_t prog(input logic [PC_W-1:0] pc);
		instr_t r;
		case (pc)
			6'd0:  r = mk(OP_MUL,  R_T0,  R_N,   R_SXX, 8'd0);
			6'd1:  r = mk(OP_MUL,  R_T1,  R_SX,  R_SX,  8'd0);
			6'd2:  r = mk(OP_SUB,  R_DX,  R_T0,  R_T1,  8'd0);
			6'd3:  r = mk(OP_SHL,  R_T1,  R_DX,  R_DX,  SH_SPREAD);
			6'd4:  r = mk(OP_MUL,  R_T0,  R_MRS, R_T0,  8'd0);
			6'd5:  r = mk(OP_DEG,  R_T0,  R_T1,  R_T0,  8'd0);
			6'd6:  r = mk(OP_MUL,  R_T0,  R_N,   R_SXY, 8'd0);
			6'd7:  r = mk(OP_MUL,  R_T1,  R_SX,  R_SY,  8'd0);
			6'd8:  r = mk(OP_SUB,  R_DXY, R_T0,  R_T1,  8'd0);
			6'd9:  r = mk(OP_MUL,  R_T0,  R_N,   R_SYY, 8'd0);
			6'd10: r = mk(OP_MUL,  R_T1,  R_SY,  R_SY,  8'd0);
			6'd11: r = mk(OP_SUB,  R_DY,  R_T0,  R_T1,  8'd0);
			6'd12: r = mk(OP_MUL,  R_T0,  R_DX,  R_DY,  8'd0);
			6'd13: r = mk(OP_MUL,  R_T1,  R_DXY, R_DXY, 8'd0);
			6'd14: r = mk(OP_SUB,  R_Q,   R_T0,  R_T1,  8'd0);
			6'd15: r = mk(OP_SHL,  R_T0,  R_DXY, R_DXY, SH_F);
			6'd16: r = mk(OP_DIV,  R_T0,  R_T0,  R_DX,  8'd0);
			6'd17: r = mk(OP_OUT,  R_T0,  R_T0,  R_T0,  F_SLOPE);
			6'd18: r = mk(OP_MUL,  R_T0,  R_SXX, R_SY,  8'd0);
			6'd19: r = mk(OP_MUL,  R_T1,  R_SX,  R_SXY, 8'd0);
			6'd20: r = mk(OP_SUB,  R_T0,  R_T0,  R_T1,  8'd0);
			6'd21: r = mk(OP_SHL,  R_T0,  R_T0,  R_T0,  SH_F);
			6'd22: r = mk(OP_DIV,  R_T0,  R_T0,  R_DX,  8'd0);
			6'd23: r = mk(OP_OUT,  R_T0,  R_T0,  R_T0,  F_ICPT);
			6'd24: r = mk(OP_MUL,  R_D2,  R_DX,  R_DX,  8'd0);
			6'd25: r = mk(OP_MUL,  R_NN2, R_N,   R_N2,  8'd0);
			6'd26: r = mk(OP_SHL,  R_QS,  R_Q,   R_Q,   SH_2F);
			6'd27: r = mk(OP_MUL,  R_T0,  R_D2,  R_N2,  8'd0);
			6'd28: r = mk(OP_DIV,  R_T0,  R_QS,  R_T0,  8'd0);
			6'd29: r = mk(OP_SQRT, R_T0,  R_T0,  R_T0,  8'd0);
			6'd30: r = mk(OP_OUT,  R_T0,  R_T0,  R_T0,  F_SERR);
			6'd31: r = mk(OP_MUL,  R_T0,  R_Q,   R_SXX, 8'd0);
			6'd32: r = mk(OP_SHL,  R_T0,  R_T0,  R_T0,  SH_2F);
			6'd33: r = mk(OP_MUL,  R_T1,  R_D2,  R_NN2, 8'd0);
			6'd34: r = mk(OP_DIV,  R_T0,  R_T0,  R_T1,  8'd0);
			6'd35: r = mk(OP_SQRT, R_T0,  R_T0,  R_T0,  8'd0);
			6'd36: r = mk(OP_OUT,  R_T0,  R_T0,  R_T0,  F_IERR);
			6'd37: r = mk(OP_MUL,  R_T1,  R_DX,  R_NN2, 8'd0);
			6'd38: r = mk(OP_DIV,  R_T0,  R_QS,  R_T1,  8'd0);
			6'd39: r = mk(OP_SQRT, R_T0,  R_T0,  R_T0,  8'd0);
			6'd40: r = mk(OP_OUT,  R_T0,  R_T0,  R_T0,  F_RSD);
			default: r = mk(OP_END, R_T0, R_T0, R_T0, 8'd0);
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/least_squares_line_fit.sv =====
// Samples: one accepted per cycle while s_tready is high, through a registered
// product stage into the running sums. A set of fewer than three or too many
// samples is answered from the drain and check states, without running a fit.
// A full fit uses the bit-serial 192-bit multiplier (17 products) and the divider.
// No samples are accepted while a fit runs. Reset clears sums and control,
// and sets min_rel_spread to 7.
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Streaming least-squares line fit with slope, intercept and error figures.
// ----------------------------------------------------------------------------
module least_squares_line_fit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // x_sample[15:0], y_sample[31:16]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// slope, intercept, slope_error, intercept_error, residual_sd (48 each),
	// point_count[252:240], status[255:253]
	output logic [255:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [lslf_pkg::MRS_W-1:0]              mrs_q;
	logic                                    in_fire, acc_clear;
	lslf_pkg::acc_sts_t                      acc;
	lslf_pkg::dp_cmd_t                       cmd;
	lslf_pkg::dp_sts_t                       dsts;
	logic signed [lslf_pkg::SX_W-1:0]        sum_x, sum_y;
	logic [lslf_pkg::SXX_W-1:0]              sum_xx, sum_yy;
	logic signed [lslf_pkg::SXY_W-1:0]       sum_xy;
	logic [lslf_pkg::FLD_W-1:0]              slope, intercept, slope_error;
	logic [lslf_pkg::FLD_W-1:0]              intercept_error, residual_sd;
	logic [2:0]                              status;
	logic [lslf_pkg::CNT_W-1:0]              point_count;

	assign pready  = 1'b1;
	assign in_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrs_q <= 16'd7;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			mrs_q <= pwdata[lslf_pkg::MRS_W-1:0];
		end
	end

	assign prdata = paddr[2] ? 32'd0 : {16'd0, mrs_q};

	lslf_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.x_sample (s_tdata[15:0]),
		.y_sample (s_tdata[31:16]),
		.clear    (acc_clear),
		.sts      (acc),
		.sum_x    (sum_x),
		.sum_y    (sum_y),
		.sum_xx   (sum_xx),
		.sum_yy   (sum_yy),
		.sum_xy   (sum_xy)
	);

	lslf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (dsts),
		.acc             (acc),
		.sum_x           (sum_x),
		.sum_y           (sum_y),
		.sum_xx          (sum_xx),
		.sum_yy          (sum_yy),
		.sum_xy          (sum_xy),
		.min_rel_spread  (mrs_q),
		.slope           (slope),
		.intercept       (intercept),
		.slope_error     (slope_error),
		.intercept_error (intercept_error),
		.residual_sd     (residual_sd)
	);

	lslf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.in_last     (s_tlast),
		.in_ready    (s_tready),
		.acc         (acc),
		.acc_clear   (acc_clear),
		.cmd         (cmd),
		.dsts        (dsts),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.status      (status),
		.point_count (point_count)
	);

	assign m_tdata = {status, point_count, residual_sd, intercept_error,
	                  slope_error, intercept, slope};

endmodule

// ===== rtl/core/lslf_accum.sv =====
// ----------------------------------------------------------------------------
// lslf_accum
// Sample accumulator: registered products, then running sums and count.
// ----------------------------------------------------------------------------
module lslf_accum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_fire,
	input  logic signed [lslf_pkg::SMP_W-1:0]   x_sample,
	input  logic signed [lslf_pkg::SMP_W-1:0]   y_sample,
	input  logic                                clear,
	output lslf_pkg::acc_sts_t                  sts,
	output logic signed [lslf_pkg::SX_W-1:0]    sum_x,
	output logic signed [lslf_pkg::SX_W-1:0]    sum_y,
	output logic [lslf_pkg::SXX_W-1:0]          sum_xx,
	output logic [lslf_pkg::SXX_W-1:0]          sum_yy,
	output logic signed [lslf_pkg::SXY_W-1:0]   sum_xy
);

	localparam int PW = 2 * lslf_pkg::SMP_W;

	logic                            v_s1;
	logic signed [lslf_pkg::SMP_W-1:0] x_s1, y_s1;
	logic signed [PW-1:0]            xx_s1, yy_s1, xy_s1;
	logic [lslf_pkg::CNT_W-1:0]      count_q;
	logic                            ovf_q;

	always_ff @(posedge clk) begin
		x_s1  <= x_sample;
		y_s1  <= y_sample;
		xx_s1 <= x_sample * x_sample;
		yy_s1 <= y_sample * y_sample;
		xy_s1 <= x_sample * y_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			sum_x   <= '0;
			sum_y   <= '0;
			sum_xx  <= '0;
			sum_yy  <= '0;
			sum_xy  <= '0;
		end else begin
			v_s1 <= in_fire;
			if (clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				sum_x   <= '0;
				sum_y   <= '0;
				sum_xx  <= '0;
				sum_yy  <= '0;
				sum_xy  <= '0;
			end else if (v_s1) begin
				if (count_q < lslf_pkg::CNT_W'(lslf_pkg::MAX_SAMPLES)) begin
					count_q <= count_q + 1'b1;
					sum_x   <= sum_x + {{(lslf_pkg::SX_W-lslf_pkg::SMP_W){x_s1[lslf_pkg::SMP_W-1]}}, x_s1};
					sum_y   <= sum_y + {{(lslf_pkg::SX_W-lslf_pkg::SMP_W){y_s1[lslf_pkg::SMP_W-1]}}, y_s1};
					sum_xx  <= sum_xx + {{(lslf_pkg::SXX_W-PW){1'b0}}, xx_s1};
					sum_yy  <= sum_yy + {{(lslf_pkg::SXX_W-PW){1'b0}}, yy_s1};
					sum_xy  <= sum_xy + {{(lslf_pkg::SXY_W-PW){xy_s1[PW-1]}}, xy_s1};
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign sts.count = count_q;
	assign sts.ovf   = ovf_q;

endmodule

// ===== rtl/core/lslf_dp.sv =====
// ----------------------------------------------------------------------------
// lslf_dp
// Fit engine datapath: wide register file, serial multiply, restoring
// divide, digit-by-digit root and output field formatting.
// ----------------------------------------------------------------------------
module lslf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lslf_pkg::dp_cmd_t                   cmd,
	output lslf_pkg::dp_sts_t                   sts,
	input  lslf_pkg::acc_sts_t                  acc,
	input  logic signed [lslf_pkg::SX_W-1:0]    sum_x,
	input  logic signed [lslf_pkg::SX_W-1:0]    sum_y,
	input  logic [lslf_pkg::SXX_W-1:0]          sum_xx,
	input  logic [lslf_pkg::SXX_W-1:0]          sum_yy,
	input  logic signed [lslf_pkg::SXY_W-1:0]   sum_xy,
	input  logic [lslf_pkg::MRS_W-1:0]          min_rel_spread,
	output logic [lslf_pkg::FLD_W-1:0]          slope,
	output logic [lslf_pkg::FLD_W-1:0]          intercept,
	output logic [lslf_pkg::FLD_W-1:0]          slope_error,
	output logic [lslf_pkg::FLD_W-1:0]          intercept_error,
	output logic [lslf_pkg::FLD_W-1:0]          residual_sd
);

	localparam int W  = lslf_pkg::W;
	localparam int FW = lslf_pkg::FLD_W;
	localparam int SQ = lslf_pkg::SQ_IN_W;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_PREP = 4'b0010,
		PH_ITER = 4'b0100,
		PH_WB   = 4'b1000
	} ph_t;

	logic [W-1:0] rf [2**lslf_pkg::RA];
	logic [W-1:0] rd_a_q, rd_b_q;

	ph_t                      ph_q, ph_d;
	logic [lslf_pkg::IT_W-1:0] it_q, it_d;
	logic                     deg_q, deg_d, sat_q, sat_d;
	logic                     neg_q, neg_d;
	logic [W-1:0]             acc_q, acc_d, a_q, a_d, b_q, b_d;
	logic [FW-1:0]            slope_d, icpt_d, serr_d, ierr_d, rsd_d;

	logic                     rf_we, op_wr;
	logic [lslf_pkg::RA-1:0]  rf_wa;
	logic [W-1:0]             rf_wd, ld_val;
	lslf_pkg::op_t            op;

	logic [W-1:0] mul_sum, neg_a, neg_q_val;
	logic [W:0]   div_tr, div_diff;
	logic         div_ge;
	logic [W-1:0] sq_tr, sq_cmp;
	logic         sq_ge;
	logic         pos_ovf, neg_ovf, uns_ovf;
	logic [FW-1:0] sgn_val, uns_val;

	assign op = cmd.instr.op;

	// load values from the sample count, the sums and min_rel_spread
	always_comb begin
		case (cmd.ld_sel)
			3'd0: ld_val = {{(W-lslf_pkg::CNT_W){1'b0}}, acc.count};
			3'd1: ld_val = {{(W-lslf_pkg::CNT_W){1'b0}}, acc.count - 2'd2};
			3'd2: ld_val = {{(W-lslf_pkg::SX_W){sum_x[lslf_pkg::SX_W-1]}}, sum_x};
			3'd3: ld_val = {{(W-lslf_pkg::SX_W){sum_y[lslf_pkg::SX_W-1]}}, sum_y};
			3'd4: ld_val = {{(W-lslf_pkg::SXX_W){1'b0}}, sum_xx};
			3'd5: ld_val = {{(W-lslf_pkg::SXX_W){1'b0}}, sum_yy};
			3'd6: ld_val = {{(W-lslf_pkg::SXY_W){sum_xy[lslf_pkg::SXY_W-1]}}, sum_xy};
			default: ld_val = {{(W-lslf_pkg::MRS_W){1'b0}}, min_rel_spread};
		endcase
	end

	always_comb begin
		case (op)
			lslf_pkg::OP_MUL, lslf_pkg::OP_SUB, lslf_pkg::OP_SHL,
			lslf_pkg::OP_DIV, lslf_pkg::OP_SQRT: op_wr = 1'b1;
			default: op_wr = 1'b0;
		endcase
	end

	assign neg_q_val = -a_q;
	assign rf_we = cmd.ld_we || ((ph_q == PH_WB) && op_wr);
	assign rf_wa = cmd.ld_we ? {1'b0, cmd.ld_sel} : cmd.instr.d;

	always_comb begin
		case (op)
			lslf_pkg::OP_DIV:  rf_wd = neg_q ? neg_q_val : a_q;
			lslf_pkg::OP_SQRT: rf_wd = b_q;
			default:           rf_wd = acc_q;
		endcase
		if (cmd.ld_we) begin
			rf_wd = ld_val;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q <= rf[cmd.instr.a];
		rd_b_q <= rf[cmd.instr.b];
		if (rf_we) begin
			rf[rf_wa] <= rf_wd;
		end
	end

	// iteration and formatting helpers
	assign mul_sum  = b_q[0] ? acc_q + a_q : acc_q;
	assign neg_a    = -rd_a_q;
	assign div_tr   = {acc_q, a_q[W-1]};
	assign div_diff = div_tr - {1'b0, b_q};
	assign div_ge   = div_tr >= {1'b0, b_q};
	assign sq_tr    = {acc_q[W-3:0], a_q[SQ-1 -: 2]};
	assign sq_cmp   = {b_q[W-3:0], 2'b01};
	assign sq_ge    = sq_tr >= sq_cmp;

	assign pos_ovf = !rd_a_q[W-1] && (|rd_a_q[W-2:FW-1]);
	assign neg_ovf = rd_a_q[W-1] && !(&rd_a_q[W-2:FW-1]);
	assign uns_ovf = |rd_a_q[W-1:FW];
	assign sgn_val = pos_ovf ? {1'b0, {(FW-1){1'b1}}} :
	                 neg_ovf ? {1'b1, {(FW-1){1'b0}}} : rd_a_q[FW-1:0];
	assign uns_val = uns_ovf ? {FW{1'b1}} : rd_a_q[FW-1:0];

	always_comb begin
		ph_d    = ph_q;
		it_d    = it_q;
		deg_d   = deg_q;
		sat_d   = sat_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		a_d     = a_q;
		b_d     = b_q;
		slope_d = slope;
		icpt_d  = intercept;
		serr_d  = slope_error;
		ierr_d  = intercept_error;
		rsd_d   = residual_sd;
		if (cmd.clr_sat) begin
			sat_d = 1'b0;
		end
		if (cmd.zero_fields) begin
			slope_d = '0;
			icpt_d  = '0;
			serr_d  = '0;
			ierr_d  = '0;
			rsd_d   = '0;
		end
		case (ph_q)
			PH_IDLE: begin
				if (cmd.start) begin
					ph_d = PH_PREP;
				end
			end
			PH_PREP: begin
				ph_d = PH_WB;
				case (op)
					lslf_pkg::OP_MUL: begin
						acc_d = '0;
						a_d   = rd_a_q;
						b_d   = rd_b_q;
						it_d  = lslf_pkg::IT_W'(W - 1);
						ph_d  = PH_ITER;
					end
					lslf_pkg::OP_SUB: begin
						acc_d = rd_a_q - rd_b_q;
					end
					lslf_pkg::OP_SHL: begin
						acc_d = rd_a_q << cmd.instr.imm;
					end
					lslf_pkg::OP_DIV: begin
						neg_d = rd_a_q[W-1];
						a_d   = rd_a_q[W-1] ? neg_a : rd_a_q;
						b_d   = rd_b_q;
						acc_d = '0;
						it_d  = lslf_pkg::IT_W'(W - 1);
						ph_d  = PH_ITER;
					end
					lslf_pkg::OP_SQRT: begin
						if (|rd_a_q[W-1:SQ]) begin
							// root of at least 2^48: force saturation downstream
							b_d = {{(W-FW-1){1'b0}}, 1'b1, {FW{1'b0}}};
						end else begin
							a_d   = rd_a_q;
							acc_d = '0;
							b_d   = '0;
							it_d  = lslf_pkg::IT_W'(FW - 1);
							ph_d  = PH_ITER;
						end
					end
					lslf_pkg::OP_DEG: begin
						deg_d = ($signed(rd_a_q) < $signed(rd_b_q)) || (rd_a_q == '0);
					end
					lslf_pkg::OP_OUT: begin
						case (cmd.instr.imm)
							lslf_pkg::F_SLOPE: begin
								slope_d = sgn_val;
								sat_d   = sat_d | pos_ovf | neg_ovf;
							end
							lslf_pkg::F_ICPT: begin
								icpt_d = sgn_val;
								sat_d  = sat_d | pos_ovf | neg_ovf;
							end
							lslf_pkg::F_SERR: begin
								serr_d = uns_val;
								sat_d  = sat_d | uns_ovf;
							end
							lslf_pkg::F_IERR: begin
								ierr_d = uns_val;
								sat_d  = sat_d | uns_ovf;
							end
							default: begin
								rsd_d = uns_val;
								sat_d = sat_d | uns_ovf;
							end
						endcase
					end
					default: ;
				endcase
			end
			PH_ITER: begin
				it_d = it_q - 1'b1;
				if (it_q == '0) begin
					ph_d = PH_WB;
				end
				case (op)
					lslf_pkg::OP_MUL: begin
						acc_d = mul_sum;
						a_d   = a_q << 1;
						b_d   = b_q >> 1;
					end
					lslf_pkg::OP_DIV: begin
						acc_d = div_ge ? div_diff[W-1:0] : div_tr[W-1:0];
						a_d   = {a_q[W-2:0], div_ge};
					end
					default: begin
						acc_d = sq_ge ? sq_tr - sq_cmp : sq_tr;
						b_d   = {b_q[W-2:0], sq_ge};
						a_d   = a_q << 2;
					end
				endcase
			end
			PH_WB: begin
				ph_d = PH_IDLE;
			end
			default: begin
				ph_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			it_q  <= '0;
			deg_q <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			ph_q  <= ph_d;
			it_q  <= it_d;
			deg_q <= deg_d;
			sat_q <= sat_d;
		end
	end

	always_ff @(posedge clk) begin
		neg_q           <= neg_d;
		acc_q           <= acc_d;
		a_q             <= a_d;
		b_q             <= b_d;
		slope           <= slope_d;
		intercept       <= icpt_d;
		slope_error     <= serr_d;
		intercept_error <= ierr_d;
		residual_sd     <= rsd_d;
	end

	assign sts.done = (ph_q == PH_WB);
	assign sts.deg  = deg_q;
	assign sts.sat  = sat_q;

endmodule

// ===== rtl/core/lslf_ctrl.sv =====
// ----------------------------------------------------------------------------
// lslf_ctrl
// Controller: sample intake, early result checks, sum load and the fit
// program sequencer, plus the result valid/status register.
// ----------------------------------------------------------------------------
module lslf_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_fire,
	input  logic                        in_last,
	output logic                        in_ready,
	input  lslf_pkg::acc_sts_t          acc,
	output logic                        acc_clear,
	output lslf_pkg::dp_cmd_t           cmd,
	input  lslf_pkg::dp_sts_t           dsts,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [2:0]                  status,
	output logic [lslf_pkg::CNT_W-1:0]  point_count
);

	typedef enum logic [5:0] {
		S_ACC   = 6'b000001,
		S_DRAIN = 6'b000010,
		S_CHK   = 6'b000100,
		S_LOAD  = 6'b001000,
		S_ISSUE = 6'b010000,
		S_BUSY  = 6'b100000
	} state_t;

	state_t                      state_q, state_d;
	logic [lslf_pkg::PC_W-1:0]   pc_q, pc_d;
	logic [lslf_pkg::LD_W-1:0]   ld_q, ld_d;
	logic                        emit;
	logic [2:0]                  emit_status;
	logic                        out_free;
	lslf_pkg::instr_t            instr;

	assign instr    = lslf_pkg::prog(pc_q);
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_ACC);

	always_comb begin
		state_d         = state_q;
		pc_d            = pc_q;
		ld_d            = ld_q;
		emit            = 1'b0;
		emit_status     = lslf_pkg::ST_OK;
		acc_clear       = 1'b0;
		cmd.start       = 1'b0;
		cmd.instr       = instr;
		cmd.ld_we       = 1'b0;
		cmd.ld_sel      = ld_q;
		cmd.clr_sat     = 1'b0;
		cmd.zero_fields = 1'b0;
		case (state_q)
			S_ACC: begin
				if (in_fire && in_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// let the product stage land in the sums
				state_d = S_CHK;
			end
			S_CHK: begin
				if (out_free) begin
					if (acc.ovf || (acc.count < lslf_pkg::CNT_W'(3))) begin
						emit            = 1'b1;
						emit_status     = acc.ovf ? lslf_pkg::ST_OVF : lslf_pkg::ST_FEW;
						cmd.zero_fields = 1'b1;
						acc_clear       = 1'b1;
						state_d         = S_ACC;
					end else begin
						ld_d    = '0;
						state_d = S_LOAD;
					end
				end
			end
			S_LOAD: begin
				cmd.ld_we   = 1'b1;
				cmd.clr_sat = 1'b1;
				ld_d        = ld_q + 1'b1;
				if (ld_q == lslf_pkg::LD_LAST) begin
					acc_clear = 1'b1;
					pc_d      = '0;
					state_d   = S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (instr.op == lslf_pkg::OP_END) begin
					emit        = 1'b1;
					emit_status = dsts.sat ? lslf_pkg::ST_SAT : lslf_pkg::ST_OK;
					state_d     = S_ACC;
				end else begin
					cmd.start = 1'b1;
					state_d   = S_BUSY;
				end
			end
			S_BUSY: begin
				if (dsts.done) begin
					if ((instr.op == lslf_pkg::OP_DEG) && dsts.deg) begin
						emit            = 1'b1;
						emit_status     = lslf_pkg::ST_DEG;
						cmd.zero_fields = 1'b1;
						state_d         = S_ACC;
					end else begin
						pc_d    = pc_q + 1'b1;
						state_d = S_ISSUE;
					end
				end
			end
			default: begin
				state_d = S_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_ACC;
			pc_q      <= '0;
			ld_q      <= '0;
			out_valid <= 1'b0;
			status    <= lslf_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			ld_q    <= ld_d;
			if (emit) begin
				out_valid <= 1'b1;
				status    <= emit_status;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// capture the sample count before the sums are cleared
	always_ff @(posedge clk) begin
		if ((state_q == S_CHK) && out_free) begin
			point_count <= acc.count;
		end
	end

endmodule

// ===== rtl/core/lslf_checker.sv =====
// ----------------------------------------------------------------------------
// lslf_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lslf_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [255:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[255:253] <= lslf_pkg::ST_OVF))
		else $error("status code out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[255:253] == lslf_pkg::ST_FEW ||
		m_tdata[255:253] == lslf_pkg::ST_DEG ||
		m_tdata[255:253] == lslf_pkg::ST_OVF) |-> (m_tdata[239:0] == 240'd0))
		else $error("failed fit carries nonzero numeric fields");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[252:240] <= lslf_pkg::CNT_W'(lslf_pkg::MAX_SAMPLES)))
		else $error("point count above capacity");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/lslf_fit_checker.sv =====
// ----------------------------------------------------------------------------
// lslf_fit_checker
// Watches the sample, result and register channels of the line fit, predicts
// every fit result with exact wide integer math and compares it field by field.
// ----------------------------------------------------------------------------
module lslf_fit_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [31:0]  s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [255:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic [31:0]  prdata,
	input  logic         pready,
	output int           errors,
	output int           pending,
	output int           results_seen,
	output int           fits_ok
);

	typedef logic signed [383:0] wide_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [12:0] point_count;
		logic [47:0] residual_sd;
		logic [47:0] intercept_error;
		logic [47:0] slope_error;
		logic [47:0] intercept;
		logic [47:0] slope;
	} fit_t;

	localparam logic [47:0] U48_MAX = 48'hFFFF_FFFF_FFFF;

	fit_t   fit_queue[$];
	int     n_pts;
	longint acc_x, acc_y, acc_xx, acc_yy, acc_xy;
	bit     dropped;
	logic [15:0] spread_min;

	assign pending = fit_queue.size();

	function automatic wide_t floor_sqrt(input wide_t a);
		logic [385:0] rem;
		logic [385:0] root;
		logic [385:0] trial;
		rem = '0;
		root = '0;
		for (int i = 191; i >= 0; i--) begin
			rem = (rem << 2) | a[2*i +: 2];
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return wide_t'(root);
	endfunction

	function automatic logic [47:0] clamp_u48(input wide_t v, inout bit sat);
		if (v > wide_t'(U48_MAX)) begin
			sat = 1'b1;
			return U48_MAX;
		end
		return v[47:0];
	endfunction

	// truncating signed quotient, clamped to the signed 48-bit range
	function automatic logic [47:0] quot_s48(input wide_t num, input wide_t den,
		inout bit sat);
		bit    neg;
		wide_t mag;
		wide_t lim;
		neg = num < 0;
		mag = neg ? -num : num;
		mag = mag / den;
		lim = neg ? (wide_t'(1) <<< 47) : ((wide_t'(1) <<< 47) - 1);
		if (mag > lim) begin
			sat = 1'b1;
			mag = lim;
		end
		mag = neg ? -mag : mag;
		return mag[47:0];
	endfunction

	function automatic fit_t solve_line();
		fit_t  r;
		wide_t n, n2, sx, sy, sxx, syy, sxy, dx, dxy, dy, q, dx2, icpt, k2;
		bit    sat;
		r = '0;
		sat = 1'b0;
		r.point_count = 13'(n_pts);
		if (dropped) begin
			r.status = lslf_pkg::ST_OVF;
		end else if (n_pts < 3) begin
			r.status = lslf_pkg::ST_FEW;
		end else begin
			n = n_pts;
			n2 = n_pts - 2;
			sx = acc_x;
			sy = acc_y;
			sxx = acc_xx;
			syy = acc_yy;
			sxy = acc_xy;
			dx = n * sxx - sx * sx;
			dxy = n * sxy - sx * sy;
			dy = n * syy - sy * sy;
			if (dx == 0 || dx * 65536 < wide_t'(spread_min) * n * sxx) begin
				r.status = lslf_pkg::ST_DEG;
			end else begin
				k2 = wide_t'(1) <<< 32;
				icpt = sxx * sy - sx * sxy;
				q = dx * dy - dxy * dxy;
				if (q < 0)
					q = 0;
				dx2 = dx * dx;
				r.slope = quot_s48(dxy * 65536, dx, sat);
				r.intercept = quot_s48(icpt * 65536, dx, sat);
				r.slope_error = clamp_u48(floor_sqrt((q * k2) / (dx2 * n2)), sat);
				r.intercept_error = clamp_u48(
					floor_sqrt((q * sxx * k2) / (dx2 * n * n2)), sat);
				r.residual_sd = clamp_u48(floor_sqrt((q * k2) / (dx * n * n2)), sat);
				r.status = sat ? lslf_pkg::ST_SAT : lslf_pkg::ST_OK;
			end
		end
		return r;
	endfunction

	function automatic void report(input string name, input logic [47:0] want,
		input logic [47:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint x, y;
		fit_t   want, got;
		if (!arst_n) begin
			n_pts = 0;
			acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
			dropped = 1'b0;
			spread_min = 16'd7;
			fit_queue.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite && paddr[2] == 1'b0)
					spread_min = pwdata[15:0];
				else if (!pwrite && paddr[2] == 1'b0 && prdata !== {16'd0, spread_min}) begin
					$display("%0t: register read mismatch: expected %h, actual %h",
						$time, spread_min, prdata);
					errors++;
				end
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				if (fit_queue.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h", $time, got);
					errors++;
				end else begin
					want = fit_queue.pop_front();
					report("slope", want.slope, got.slope);
					report("intercept", want.intercept, got.intercept);
					report("slope_error", want.slope_error, got.slope_error);
					report("intercept_error", want.intercept_error, got.intercept_error);
					report("residual_sd", want.residual_sd, got.residual_sd);
					report("point_count", 48'(want.point_count), 48'(got.point_count));
					report("status", 48'(want.status), 48'(got.status));
					if (want.status == lslf_pkg::ST_OK)
						fits_ok++;
				end
			end
			if (s_tvalid && s_tready) begin
				x = longint'($signed(s_tdata[15:0]));
				y = longint'($signed(s_tdata[31:16]));
				if (n_pts < lslf_pkg::MAX_SAMPLES) begin
					n_pts++;
					acc_x += x; acc_y += y;
					acc_xx += x * x; acc_yy += y * y; acc_xy += x * y;
				end else begin
					dropped = 1'b1;
				end
				if (s_tlast) begin
					fit_queue.insert(fit_queue.size(), solve_line());
					n_pts = 0;
					acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
					dropped = 1'b0;
				end
			end
		end
	end

endmodule

// ===== tb/tb_least_squares_line_fit.sv =====
// ----------------------------------------------------------------------------
// tb_least_squares_line_fit
// Drives sample sets and register settings into the line fit with random
// gaps and stalls; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_least_squares_line_fit;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [255:0] m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	int errors, pending, results_seen, fits_ok;
	int samples_sent;
	bit s_took, m_took;

	always #2 clk = ~clk;

	least_squares_line_fit uut (.*);

	lslf_fit_checker chk (.*);

	always @(posedge clk) begin
		s_took <= s_tvalid & s_tready;
		m_took <= m_tvalid & m_tready;
	end

	initial begin
		#40_000_000;
		$display("tb_least_squares_line_fit failed");
		$finish;
	end

	// receiver: random stalls, one long hold-off to back up the block
	initial begin
		int gap;
		int taken;
		taken = 0;
		forever begin
			gap = (taken == 12) ? 9000 : $urandom_range(0, 14);
			if (taken != 12 && $urandom_range(0, 3) == 0)
				gap = 0;
			m_tready = 1'b0;
			repeat (gap) @(negedge clk);
			m_tready = 1'b1;
			do @(negedge clk); while (!m_took);
			taken++;
		end
	end

	task automatic push_sample(input logic [15:0] x, input logic [15:0] y,
		input logic lst, input bit eager);
		int gap;
		gap = eager ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {y, x};
		s_tlast = lst;
		s_tvalid = 1'b1;
		do @(negedge clk); while (!s_took);
		samples_sent++;
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic reg_access(input logic [2:0] addr, input logic [31:0] data,
		input logic wr);
		psel = 1'b1;
		pwrite = wr;
		paddr = addr;
		pwdata = data;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [15:0] clip16(input int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return 16'h8000;
		return 16'(v);
	endfunction

	// one set with random length and one of several data shapes
	task automatic random_set();
		int len, shape, slope_q, offs, cx, x, y;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
		shape = $urandom_range(0, 3);
		slope_q = $urandom_range(0, 2000) - 1000;
		offs = $urandom_range(0, 65535) - 32768;
		cx = $urandom_range(0, 65535) - 32768;
		for (int i = 0; i < len; i++) begin
			case (shape)
				0: begin
					x = $urandom_range(0, 65535) - 32768;
					y = $urandom_range(0, 65535) - 32768;
				end
				1: begin
					x = $urandom_range(0, 400) - 200;
					y = offs + (slope_q * x) / 16 + $urandom_range(0, 64) - 32;
				end
				2: begin
					x = cx + $urandom_range(0, 8) - 4;
					y = $urandom_range(0, 65535) - 32768;
				end
				default: begin
					x = $urandom_range(0, 65535) - 32768;
					y = offs + (slope_q * (x / 256)) + $urandom_range(0, 1000) - 500;
				end
			endcase
			push_sample(clip16(x), clip16(y), i == len - 1, 1'b0);
		end
	endtask

	initial begin
		logic [15:0] spreads[4];
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		reg_access(3'd0, 32'd0, 1'b0);

		// short sets, extremes, degenerate spread
		push_sample(16'h8000, 16'h7FFF, 1'b1, 1'b0);
		push_sample(16'h7FFF, 16'h8000, 1'b0, 1'b0);
		push_sample(16'h0001, 16'h0002, 1'b1, 1'b0);
		push_sample(16'h8000, 16'h8000, 1'b0, 1'b0);
		push_sample(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
		push_sample(16'h0000, 16'hFFFF, 1'b1, 1'b0);
		push_sample(16'h0005, 16'h0010, 1'b0, 1'b0);
		push_sample(16'h0005, 16'h8000, 1'b0, 1'b0);
		push_sample(16'h0005, 16'h7FFF, 1'b1, 1'b0);
		push_sample(16'h0000, 16'h0003, 1'b0, 1'b0);
		push_sample(16'h0001, 16'h0005, 1'b0, 1'b0);
		push_sample(16'h0002, 16'h0007, 1'b1, 1'b0);
		drain();

		// no spread floor: tiny spread far from zero pushes toward saturation
		reg_access(3'd0, 32'd0, 1'b1);
		reg_access(3'd4, 32'h0000_FFFF, 1'b1);
		reg_access(3'd0, 32'd0, 1'b0);
		push_sample(16'h7FFF, 16'h8000, 1'b0, 1'b0);
		push_sample(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
		push_sample(16'h7FFE, 16'h8000, 1'b0, 1'b0);
		push_sample(16'h7FFE, 16'h7FFF, 1'b1, 1'b0);
		push_sample(16'h8001, 16'h7FFF, 1'b0, 1'b0);
		push_sample(16'h8000, 16'h8000, 1'b0, 1'b0);
		push_sample(16'h8000, 16'h7FFF, 1'b1, 1'b0);
		drain();

		spreads[0] = 16'hFFFF;
		spreads[1] = 16'h0000;
		spreads[2] = 16'($urandom_range(1, 3000));
		spreads[3] = 16'd7;
		foreach (spreads[k]) begin
			reg_access(3'd0, {16'($urandom), spreads[k]}, 1'b1);
			reg_access(3'd0, 32'd0, 1'b0);
			while (samples_sent < 185 * (k + 1))
				random_set();
			drain();
		end

		$display("run covered %0d samples over four spread settings with random stalls",
			samples_sent);
		$display("%0d results checked, %0d of them full fits", results_seen, fits_ok);
		if (errors == 0 && pending == 0) begin
			$display("tb_least_squares_line_fit passed");
		end else begin
			$display("tb_least_squares_line_fit failed");
		end
		$finish;
	end

endmodule
